FILE: hdl/modexp_with_fermat_inverse_assert.svh
// ----------------------------------------------------------------------------
// modexp_with_fermat_inverse assertion macros
// Shared concurrent assertion forms for the modexp checker.
// ----------------------------------------------------------------------------
`ifndef MODEXP_WITH_FERMAT_INVERSE_ASSERT_SVH
`define MODEXP_WITH_FERMAT_INVERSE_ASSERT_SVH

// same-cycle implication
`define MEFI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("modexp assertion failed");

// next-cycle implication
`define MEFI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("modexp assertion failed");

`endif

FILE: hdl/mefi_pkg.sv
// ----------------------------------------------------------------------------
// mefi_pkg
// Widths, word types, control structs and the modular doubling step.
// ----------------------------------------------------------------------------
`default_nettype none

package mefi_pkg;

	localparam int MOD_WIDTH = 31;
	localparam int EXP_WIDTH = 63;
	localparam int CNT_WIDTH = $clog2(MOD_WIDTH);
	localparam int SUM_WIDTH = MOD_WIDTH + 2;

	typedef struct packed {
		logic                 req_type;
		logic [MOD_WIDTH-1:0] base_value;
		logic [EXP_WIDTH-1:0] exponent;
		logic [MOD_WIDTH-1:0] modulus;
	} req_t;

	typedef struct packed {
		logic [MOD_WIDTH-1:0] residue;
		logic                 bad_request;
	} rsp_t;

	typedef struct packed {
		logic                 load;
		logic                 red_step;
		logic                 mul_step;
		logic                 clr;
		logic                 last;
		logic                 out_load;
		logic [CNT_WIDTH-1:0] cnt;
	} ctl_cmd_t;

	typedef struct packed {
		logic bad;
		logic exp_zero;
	} dp_status_t;

	// r' = (2r + bit*addend) mod m, for r < m and addend <= m
	function automatic logic [MOD_WIDTH-1:0] mod_step(
		input logic [MOD_WIDTH-1:0] r,
		input logic                 bit_i,
		input logic [MOD_WIDTH-1:0] addend,
		input logic [MOD_WIDTH-1:0] m
	);
		logic [SUM_WIDTH-1:0] s;
		logic [SUM_WIDTH-1:0] m1;
		logic [SUM_WIDTH-1:0] m2;
		logic [SUM_WIDTH-1:0] d1;
		logic [SUM_WIDTH-1:0] d2;
		logic [MOD_WIDTH-1:0] res;
		s  = {1'b0, r, 1'b0} + (bit_i ? {2'b00, addend} : {SUM_WIDTH{1'b0}});
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		d1 = s - m1;
		d2 = s - m2;
		if (s >= m2) begin
			res = d2[MOD_WIDTH-1:0];
		end else if (s >= m1) begin
			res = d1[MOD_WIDTH-1:0];
		end else begin
			res = s[MOD_WIDTH-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/mefi_ctrl.sv
// ----------------------------------------------------------------------------
// mefi_ctrl
// Sequencer: base reduction, one square/multiply round per exponent bit,
// and the result word handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module mefi_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   req_valid,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  wire                   rsp_ready,
	input  mefi_pkg::dp_status_t  status,
	output mefi_pkg::ctl_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RED  = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [mefi_pkg::CNT_WIDTH-1:0] CNT_TOP =
		mefi_pkg::CNT_WIDTH'(mefi_pkg::MOD_WIDTH - 1);

	logic [2:0]                     state_q, state_d;
	logic [mefi_pkg::CNT_WIDTH-1:0] cnt_q, cnt_d;
	logic                           rsp_valid_q;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.cnt = cnt_q;
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					cnt_d    = CNT_TOP;
					state_d  = ST_RED;
				end
			end
			ST_RED: begin
				cmd.red_step = 1'b1;
				cmd.last     = (cnt_q == '0);
				if (cnt_q == '0) begin
					state_d = ST_CHK;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_CHK: begin
				if (status.bad || status.exp_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.clr = 1'b1;
					cnt_d   = CNT_TOP;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				cmd.last     = (cnt_q == '0);
				if (cnt_q == '0) begin
					state_d = ST_CHK;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/mefi_dp.sv
// ----------------------------------------------------------------------------
// mefi_dp
// Operand registers and two bit-serial modular multipliers (square and
// product) that share one bit counter.
// ----------------------------------------------------------------------------
`default_nettype none

module mefi_dp (
	input  wire                   clk,
	input  mefi_pkg::req_t        req,
	input  mefi_pkg::ctl_cmd_t    cmd,
	output mefi_pkg::dp_status_t  status,
	output mefi_pkg::rsp_t        rsp
);

	logic [mefi_pkg::MOD_WIDTH-1:0] base_q;
	logic [mefi_pkg::MOD_WIDTH-1:0] mod_q;
	logic [mefi_pkg::MOD_WIDTH-1:0] acc_q;
	logic [mefi_pkg::MOD_WIDTH-1:0] sq_q;
	logic [mefi_pkg::MOD_WIDTH-1:0] pr_q;
	logic [mefi_pkg::EXP_WIDTH-1:0] exp_q;
	logic                           bad_q;
	mefi_pkg::rsp_t                 rsp_q;

	logic [mefi_pkg::MOD_WIDTH-1:0] sq_add;
	logic [mefi_pkg::MOD_WIDTH-1:0] sq_nxt;
	logic [mefi_pkg::MOD_WIDTH-1:0] pr_nxt;
	logic [mefi_pkg::MOD_WIDTH-1:0] inv_exp;

	// reduction pass folds base bits in with addend one
	assign sq_add  = cmd.red_step ? mefi_pkg::MOD_WIDTH'(1) : base_q;
	assign sq_nxt  = mefi_pkg::mod_step(sq_q, base_q[cmd.cnt], sq_add, mod_q);
	assign pr_nxt  = mefi_pkg::mod_step(pr_q, acc_q[cmd.cnt], base_q, mod_q);
	assign inv_exp = req.modulus - mefi_pkg::MOD_WIDTH'(2);

	assign status.bad      = bad_q;
	assign status.exp_zero = (exp_q == '0);
	assign rsp             = rsp_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= req.base_value;
			mod_q  <= req.modulus;
			acc_q  <= (req.modulus == mefi_pkg::MOD_WIDTH'(1)) ? '0 : mefi_pkg::MOD_WIDTH'(1);
			exp_q  <= req.req_type ? mefi_pkg::EXP_WIDTH'(inv_exp) : req.exponent;
			bad_q  <= req.req_type ? (req.modulus < mefi_pkg::MOD_WIDTH'(2))
				: (req.modulus == '0);
		end
		if (cmd.load || cmd.clr) begin
			sq_q <= '0;
			pr_q <= '0;
		end else if (cmd.red_step) begin
			sq_q <= sq_nxt;
			if (cmd.last) begin
				base_q <= sq_nxt;
			end
		end else if (cmd.mul_step) begin
			sq_q <= sq_nxt;
			pr_q <= pr_nxt;
			if (cmd.last) begin
				base_q <= sq_nxt;
				if (exp_q[0]) begin
					acc_q <= pr_nxt;
				end
				exp_q <= exp_q >> 1;
			end
		end
		if (cmd.out_load) begin
			rsp_q.residue     <= bad_q ? '0 : acc_q;
			rsp_q.bad_request <= bad_q;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/modexp_with_fermat_inverse.sv
// ----------------------------------------------------------------------------
// modexp_with_fermat_inverse
// Modular exponentiation (right-to-left square and multiply) with a
// Fermat inverse mode using exponent modulus-2.
// ----------------------------------------------------------------------------
// Usage:
//   req word (req_valid/req_ready): req_type, base_value, exponent, modulus.
//   rsp word (rsp_valid/rsp_ready): residue, bad_request; one per request.
//   One request at a time; req_ready returns once the result word has been
//   loaded into the output register. The base is first reduced modulo the
//   modulus, then each bit of the effective exponent (modulus-2 in inverse
//   mode), up to its highest set bit, takes one square/multiply round; all of
//   it is done by the one-bit-per-cycle modular multipliers.
//   A rejected request (zero modulus, or modulus below two for inverse)
//   returns after the base reduction, with no exponent rounds, with residue 0
//   and bad_request set.
//   The result sits in an output register: a new request is taken while
//   it waits; a stalled receiver holds the next finished word in the core.
//   Reset (arst_n low) empties the core and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module modexp_with_fermat_inverse (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_ready,
	input  mefi_pkg::req_t  req,
	output logic            rsp_valid,
	input  wire             rsp_ready,
	output mefi_pkg::rsp_t  rsp
);

	mefi_pkg::ctl_cmd_t   cmd;
	mefi_pkg::dp_status_t status;

	mefi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mefi_dp u_dp (
		.clk    (clk),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

FILE: hdl/mefi_checker.sv
// ----------------------------------------------------------------------------
// mefi_checker
// Port-level checks on the modexp block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modexp_with_fermat_inverse_assert.svh"

module mefi_checker (
	input wire             clk,
	input wire             arst_n,
	input wire             req_valid,
	input wire             req_ready,
	input mefi_pkg::req_t  req,
	input wire             rsp_valid,
	input wire             rsp_ready,
	input mefi_pkg::rsp_t  rsp
);

	logic req_seen;

	assign req_seen = req.req_type | req_valid;

	`MEFI_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`MEFI_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp))
	`MEFI_ASSERT_IMPL(a_bad_zero, clk, arst_n, rsp_valid && rsp.bad_request, rsp.residue == '0)
	`MEFI_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_seen && req_valid && req_ready, !req_ready)

endmodule

bind modexp_with_fermat_inverse mefi_checker u_mefi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire

FILE: tb/modexp_with_fermat_inverse_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modexp_with_fermat_inverse_tb
// Sends directed and random power and inverse requests with random gaps on
// both sides. Each result word is checked against a software square and
// multiply run on the accepted request, in order of acceptance.
// ----------------------------------------------------------------------------

module modexp_with_fermat_inverse_tb;
	import mefi_pkg::*;

	localparam int RANDOM_WORDS = 1750;
	localparam int STALL_LIMIT  = 20000;
	localparam int IDLE_PCT     = 14;

	class residue_board;
		rsp_t        awaited_residues[$];
		int unsigned errors;

		function new();
			errors = 0;
		endfunction

		function rsp_t predict_residue(req_t r);
			bit [63:0] b;
			bit [63:0] e;
			bit [63:0] m;
			bit [63:0] acc;
			rsp_t      o;
			m = {33'd0, r.modulus};
			b = {33'd0, r.base_value};
			if (r.req_type ? (m < 64'd2) : (m == 64'd0)) begin
				o.residue     = '0;
				o.bad_request = 1'b1;
				return o;
			end
			e   = r.req_type ? m - 64'd2 : {1'b0, r.exponent};
			acc = 64'd1 % m;
			b   = b % m;
			while (e != 64'd0) begin
				if (e[0]) begin
					acc = (acc * b) % m;
				end
				b = (b * b) % m;
				e = e >> 1;
			end
			o.residue     = acc[MOD_WIDTH-1:0];
			o.bad_request = 1'b0;
			return o;
		endfunction

		function void take_request(req_t r);
			awaited_residues.push_back(predict_residue(r));
		endfunction

		function void match_response(rsp_t got);
			rsp_t want;
			if (awaited_residues.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected word: residue %0d bad_request %0b",
						got.residue, got.bad_request);
				end
				return;
			end
			want = awaited_residues.pop_front();
			if (got.residue !== want.residue || got.bad_request !== want.bad_request) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: residue exp %0d got %0d, bad_request exp %0b got %0b",
						want.residue, got.residue, want.bad_request, got.bad_request);
				end
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         req_valid;
	logic         req_ready;
	req_t         req;
	logic         rsp_valid;
	logic         rsp_ready;
	rsp_t         rsp;
	bit           steady;
	int unsigned  quiet_cycles;
	residue_board board;

	int unsigned primes [12] = '{2, 3, 5, 7, 11, 13, 97, 257, 7919, 65521, 1000003,
		2147483647};

	modexp_with_fermat_inverse u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit [63:0] rand_bits(int w);
		bit [63:0] v;
		v = {$urandom, $urandom};
		if (w >= 64) begin
			return v;
		end
		return v & ((64'd1 << w) - 64'd1);
	endfunction

	function automatic req_t make_req(bit t, bit [63:0] b, bit [63:0] e, bit [63:0] m);
		req_t w;
		w.req_type   = t;
		w.base_value = MOD_WIDTH'(b);
		w.exponent   = EXP_WIDTH'(e);
		w.modulus    = MOD_WIDTH'(m);
		return w;
	endfunction

	// mostly short exponents and small inverse moduli; a few full-width ones
	function automatic req_t random_request();
		bit        t;
		bit [63:0] m;
		bit [63:0] b;
		bit [63:0] e;
		int        pick;
		t    = ($urandom_range(99) < 25);
		pick = $urandom_range(99);
		if (pick < 5) begin
			case ($urandom_range(3))
				0: begin
					m = 64'd0;
				end
				1: begin
					m = 64'd1;
				end
				2: begin
					m = 64'd2;
				end
				default: begin
					m = rand_bits(MOD_WIDTH) | ((64'd1 << MOD_WIDTH) - 64'd1);
				end
			endcase
		end else if (pick < 20) begin
			m = {32'd0, primes[$urandom_range(11)]};
		end else if (t) begin
			m = rand_bits(($urandom_range(99) < 8) ? MOD_WIDTH : $urandom_range(2, 16));
		end else begin
			m = rand_bits($urandom_range(1, MOD_WIDTH));
		end
		pick = $urandom_range(99);
		if (pick < 10) begin
			b = 64'd0;
		end else if (pick < 20) begin
			b = (64'd1 << MOD_WIDTH) - 64'd1;
		end else if (pick < 30) begin
			b = m;
		end else if (pick < 45) begin
			b = rand_bits($urandom_range(1, 8));
		end else begin
			b = rand_bits(MOD_WIDTH);
		end
		pick = $urandom_range(99);
		if (pick < 5) begin
			e = 64'd0;
		end else if (pick < 8) begin
			e = 64'd1;
		end else if (pick < 10) begin
			e = (64'd1 << EXP_WIDTH) - 64'd1;
		end else if (pick < 14) begin
			e = rand_bits(EXP_WIDTH);
		end else if (pick < 34) begin
			e = rand_bits($urandom_range(13, 24));
		end else begin
			e = rand_bits($urandom_range(1, 12));
		end
		return make_req(t, b, e, m);
	endfunction

	task automatic send_word(input req_t w);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
		board.take_request(w);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			board.match_response(rsp);
		end
		rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		bit [63:0] full_mod;
		bit [63:0] full_exp;
		int        i;
		full_mod     = (64'd1 << MOD_WIDTH) - 64'd1;
		full_exp     = (64'd1 << EXP_WIDTH) - 64'd1;
		board        = new();
		steady       = 1'b0;
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero exponent, modulus one, zero modulus in both modes
		send_word(make_req(1'b0, 64'd0, 64'd0, 64'd1));
		send_word(make_req(1'b0, 64'd5, 64'd0, 64'd7));
		send_word(make_req(1'b0, 64'd9, 64'd0, 64'd0));
		send_word(make_req(1'b0, 64'd3, 64'd12345, 64'd0));
		send_word(make_req(1'b1, 64'd3, 64'd12345, 64'd0));
		send_word(make_req(1'b1, 64'd3, 64'd0, 64'd1));
		send_word(make_req(1'b0, 64'd17, 64'd12345, 64'd1));
		// full-width operands
		send_word(make_req(1'b0, full_mod, full_exp, full_mod));
		send_word(make_req(1'b0, full_mod, 64'd1, 64'd2));
		send_word(make_req(1'b0, 64'd2, 64'd1 << 62, full_mod));
		send_word(make_req(1'b0, 64'd3, 64'd1 << 62, 64'd1000003));
		// base above modulus, zero base
		send_word(make_req(1'b0, 64'd1000, 64'd3, 64'd7));
		send_word(make_req(1'b0, 64'd0, 64'd5, 64'd13));
		// inverse: smallest prime, large prime, no inverse, composite modulus
		send_word(make_req(1'b1, 64'd1, 64'd0, 64'd2));
		send_word(make_req(1'b1, 64'd2, 64'd0, 64'd3));
		send_word(make_req(1'b1, 64'd12345, 64'd0, full_mod));
		send_word(make_req(1'b1, full_mod, full_exp, full_mod));
		send_word(make_req(1'b1, 64'd14, 64'd0, 64'd7));
		send_word(make_req(1'b1, 64'd0, 64'd0, 64'd13));
		send_word(make_req(1'b1, 64'd5, 64'd0, 64'd9));
		send_word(make_req(1'b1, 64'd3, full_exp, 64'd11));

		for (i = 0; i < RANDOM_WORDS; i++) begin
			steady = (i >= 700 && i < 1000);
			send_word(random_request());
		end
		steady = 1'b0;
		req_valid <= 1'b0;

		while (board.awaited_residues.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (board.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/mefi_pkg.sv
hdl/mefi_ctrl.sv
hdl/mefi_dp.sv
hdl/modexp_with_fermat_inverse.sv
hdl/mefi_checker.sv
tb/modexp_with_fermat_inverse_tb.sv
